@@ hw/rtl/dth_pkg.sv @@
`timescale 1ns / 1ps

package dth_pkg;

  function automatic logic [63:0] pow10(input int unsigned n);
    logic [63:0] r;
    r = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      r = r * 64'd10;
    end
    return r;
  endfunction

  localparam int unsigned FracDigits = 2;
  localparam logic [63:0] Scale = pow10(FracDigits);
  localparam logic [63:0] Int64Max = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] WholeLimit = (Int64Max - (Scale - 64'd1)) / Scale;

  localparam int unsigned WholeW = $clog2(WholeLimit + 64'd1);
  localparam int unsigned FracW = $clog2(Scale);
  localparam int unsigned CountW = $clog2(FracDigits + 1);

  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic signed [63:0] value;
  } out_item_t;

  typedef struct packed {
    logic              ok;
    logic              negative;
    logic [WholeW-1:0] whole;
    logic [FracW-1:0]  frac;
  } done_t;

endpackage

@@ hw/rtl/dth_parse.sv @@
`timescale 1ns / 1ps

module dth_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  dth_pkg::in_item_t item_i,
  output dth_pkg::done_t    done_o
);

  typedef enum logic [1:0] {
    PhStart,
    PhSign,
    PhInt,
    PhFrac
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic                            negative_q, negative_d;
  logic [dth_pkg::WholeW-1:0]      whole_q, whole_d;
  logic [dth_pkg::FracW-1:0]       frac_q, frac_d;
  logic [dth_pkg::CountW-1:0]      count_q, count_d;
  logic                            failed_q, failed_d;

  logic                            digit;
  logic [3:0]                      d;
  logic [dth_pkg::WholeW+3:0]      whole_next;
  logic                            over;
  logic [dth_pkg::FracW+3:0]       frac_next;

  always_comb begin
    digit = (item_i.ch >= dth_pkg::ChZero) && (item_i.ch <= dth_pkg::ChNine);
    d = digit ? 4'(item_i.ch - dth_pkg::ChZero) : 4'd0;
    whole_next = {1'b0, whole_q, 3'b000} + {3'b000, whole_q, 1'b0}
                 + (dth_pkg::WholeW + 4)'(d);
    over = 64'(whole_next) > dth_pkg::WholeLimit;
    frac_next = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0}
                + (dth_pkg::FracW + 4)'(d);

    phase_d = phase_q;
    negative_d = negative_q;
    whole_d = whole_q;
    frac_d = frac_q;
    count_d = count_q;
    failed_d = failed_q;

    if (!failed_q) begin
      case (phase_q)
        PhStart, PhSign: begin
          if (phase_q == PhStart && item_i.ch == dth_pkg::ChMinus) begin
            negative_d = 1'b1;
            phase_d = PhSign;
          end else if (digit) begin
            whole_d = dth_pkg::WholeW'(d);
            phase_d = PhInt;
          end else begin
            failed_d = 1'b1;
          end
        end
        PhInt: begin
          if (digit) begin
            if (over) begin
              failed_d = 1'b1;
            end else begin
              whole_d = whole_next[dth_pkg::WholeW-1:0];
            end
          end else if (item_i.ch == dth_pkg::ChPoint) begin
            phase_d = PhFrac;
          end else begin
            failed_d = 1'b1;
          end
        end
        PhFrac: begin
          if (!digit) begin
            failed_d = 1'b1;
          end else if (32'(count_q) < dth_pkg::FracDigits) begin
            frac_d = frac_next[dth_pkg::FracW-1:0];
            count_d = count_q + dth_pkg::CountW'(1);
          end else if (d != 4'd0) begin
            failed_d = 1'b1;
          end
        end
        default: begin
          failed_d = 1'b1;
        end
      endcase
    end

    done_o.ok = !failed_d && (phase_d == PhInt || phase_d == PhFrac);
    done_o.negative = negative_d;
    done_o.whole = whole_d;
    done_o.frac = '0;
    for (int unsigned k = 0; k <= dth_pkg::FracDigits; k++) begin
      if (32'(count_d) == k) begin
        done_o.frac = dth_pkg::FracW'(64'(frac_d)
                      * dth_pkg::pow10(dth_pkg::FracDigits - k));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      negative_q <= 1'b0;
      whole_q <= '0;
      frac_q <= '0;
      count_q <= '0;
      failed_q <= 1'b0;
    end else if (step_i) begin
      if (item_i.last) begin
        phase_q <= PhStart;
        negative_q <= 1'b0;
        whole_q <= '0;
        frac_q <= '0;
        count_q <= '0;
        failed_q <= 1'b0;
      end else begin
        phase_q <= phase_d;
        negative_q <= negative_d;
        whole_q <= whole_d;
        frac_q <= frac_d;
        count_q <= count_d;
        failed_q <= failed_d;
      end
    end
  end

endmodule

@@ hw/rtl/decimal_text_to_hundredths.sv @@
`timescale 1ns / 1ps

// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o | in_item_i  (ch, last)
// out     | output    | out_valid_o / out_stall_i | out_item_o (ok, value)
//
// One character is taken every cycle unless the input stalls; the rate is set by the
// combinational multiply-by-ten accumulate in the character stage.
// After the edge that takes its final character, a result passes the finished-number
// register and then the output register.
// Reset is asynchronous and active low, and it clears all valid flags and the parse state.
// The input stalls only while a final character waits behind a full result path.

module decimal_text_to_hundredths (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dth_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dth_pkg::out_item_t out_item_o
);

  logic               a_valid_q;
  dth_pkg::in_item_t  a_q;
  logic               c_valid_q;
  dth_pkg::done_t     c_q;
  logic               out_valid_q;
  dth_pkg::out_item_t out_q;

  dth_pkg::done_t     done;
  dth_pkg::out_item_t result_d;
  logic [63:0]        mag;

  logic o_free;
  logic c_free;
  logic a_go;
  logic in_fire;
  logic c_load;
  logic c_go;

  assign o_free = !out_valid_q || !out_stall_i;
  assign c_free = !c_valid_q || o_free;
  assign a_go = a_valid_q && (!a_q.last || c_free);
  assign in_stall_o = a_valid_q && !a_go;
  assign in_fire = in_valid_i && !in_stall_o;
  assign c_load = a_go && a_q.last;
  assign c_go = c_valid_q && o_free;

  dth_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (a_go),
    .item_i (a_q),
    .done_o (done)
  );

  always_comb begin
    mag = 64'(c_q.whole) * dth_pkg::Scale + 64'(c_q.frac);
    result_d.ok = c_q.ok;
    if (!c_q.ok) begin
      result_d.value = '0;
    end else if (c_q.negative) begin
      result_d.value = -$signed(mag);
    end else begin
      result_d.value = $signed(mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        a_valid_q <= in_valid_i;
      end
      if (c_load) begin
        c_valid_q <= 1'b1;
      end else if (c_go) begin
        c_valid_q <= 1'b0;
      end
      if (c_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_q <= in_item_i;
    end
    if (c_load) begin
      c_q <= done;
    end
    if (c_go) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o = out_q;

endmodule

@@ hw/rtl/dth_checker.sv @@
`timescale 1ns / 1ps

module dth_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input dth_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input dth_pkg::out_item_t out_item_o
);

  localparam logic signed [63:0] MaxValue = 64'sd9223372036854775799;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("Stalled input beat changed or was dropped.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("Stalled result beat changed or was dropped.");

  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.ok |-> out_item_o.value == 64'sd0)
    else $error("Invalid number gave a nonzero value.");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.ok |->
      out_item_o.value <= MaxValue && out_item_o.value >= -MaxValue)
    else $error("Result value is out of range.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled while the result path was free.");

endmodule

bind decimal_text_to_hundredths dth_checker u_dth_checker (.*);

@@ dv/decimal_text_to_hundredths_test.sv @@
`timescale 1ns / 1ps

module decimal_text_to_hundredths_test;

  localparam int unsigned CLK_HALF = 6;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_CHARS = 1850;
  localparam logic [63:0] WHOLE_MAX = 64'd92233720368547757;

  typedef enum logic [1:0] {
    SCAN_START,
    SCAN_SIGN,
    SCAN_WHOLE,
    SCAN_FRAC
  } scan_phase_e;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  dth_pkg::in_item_t   in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  dth_pkg::out_item_t  out_item_o;

  decimal_text_to_hundredths uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  scan_phase_e        scan_phase;
  logic               scan_negative;
  logic [63:0]        whole_acc;
  logic [63:0]        frac_acc;
  int unsigned        frac_cnt;
  logic               scan_failed;

  dth_pkg::out_item_t expected_values[$];
  logic [7:0]         text_q[$];

  bit                 send_steady;
  bit                 take_steady;
  int unsigned        live_chars;
  int unsigned        numbers_sent;
  int unsigned        values_checked;
  int unsigned        rejects_seen;
  int unsigned        fail_count;
  int unsigned        cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d values outstanding.", cycle_count,
               expected_values.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void clear_scan();
    scan_phase = SCAN_START;
    scan_negative = 1'b0;
    whole_acc = '0;
    frac_acc = '0;
    frac_cnt = 0;
    scan_failed = 1'b0;
  endfunction

  // Tracks the parse of one character and queues the value a final character produces.
  function automatic void scan_char(logic [7:0] ch, logic fin);
    logic               is_digit;
    logic [63:0]        digit_val;
    logic [63:0]        next_whole;
    logic [63:0]        mag;
    dth_pkg::out_item_t res;
    is_digit = (ch >= dth_pkg::ChZero) && (ch <= dth_pkg::ChNine);
    digit_val = is_digit ? {56'd0, ch - dth_pkg::ChZero} : 64'd0;
    if (!scan_failed) begin
      live_chars++;
      case (scan_phase)
        SCAN_START, SCAN_SIGN: begin
          if (scan_phase == SCAN_START && ch == dth_pkg::ChMinus) begin
            scan_negative = 1'b1;
            scan_phase = SCAN_SIGN;
          end else if (!is_digit) begin
            scan_failed = 1'b1;
          end else begin
            whole_acc = digit_val;
            scan_phase = SCAN_WHOLE;
          end
        end
        SCAN_WHOLE: begin
          if (is_digit) begin
            next_whole = whole_acc * 64'd10 + digit_val;
            if (next_whole > WHOLE_MAX) begin
              scan_failed = 1'b1;
            end else begin
              whole_acc = next_whole;
            end
          end else if (ch == dth_pkg::ChPoint) begin
            scan_phase = SCAN_FRAC;
          end else begin
            scan_failed = 1'b1;
          end
        end
        default: begin
          if (!is_digit) begin
            scan_failed = 1'b1;
          end else if (frac_cnt < 2) begin
            frac_acc = frac_acc * 64'd10 + digit_val;
            frac_cnt++;
          end else if (digit_val != 0) begin
            scan_failed = 1'b1;
          end
        end
      endcase
    end
    if (fin) begin
      res.ok = !scan_failed && (scan_phase == SCAN_WHOLE || scan_phase == SCAN_FRAC);
      res.value = '0;
      if (res.ok) begin
        case (frac_cnt)
          0: mag = whole_acc * 64'd100;
          1: mag = whole_acc * 64'd100 + frac_acc * 64'd10;
          default: mag = whole_acc * 64'd100 + frac_acc;
        endcase
        res.value = scan_negative ? 64'd0 - mag : mag;
      end
      expected_values.push_back(res);
      numbers_sent++;
      clear_scan();
    end
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic fin);
    int unsigned gap;
    gap = send_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= '{ch: ch, last: fin};
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    scan_char(ch, fin);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i]);
    end
  endtask

  task automatic send_number();
    for (int i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
  endtask

  task automatic send_text(input string s);
    push_text(s);
    send_number();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_basic_forms();
    send_text("0");
    send_text("-0");
    send_text("7");
    send_text("5.");
    send_text("12.5");
    send_text("-7.05");
    send_text("003.10");
    wait_drained();
  endtask

  task automatic test_fraction_rules();
    send_text("1.230");
    send_text("1.234");
    send_text("2.50000");
    send_text("0.009");
    wait_drained();
  endtask

  task automatic test_malformed();
    send_text("-");
    send_text(".");
    send_text("-.5");
    send_text("1..2");
    send_text("1-");
    send_text("--1");
    text_q.push_back(8'h00);
    send_number();
    push_text("4");
    text_q.push_back(8'h00);
    send_number();
    push_text("1");
    text_q.push_back(8'hFF);
    send_number();
    wait_drained();
  endtask

  task automatic test_range_edges();
    send_text("92233720368547757.99");
    send_text("-92233720368547757.99");
    send_text("92233720368547758");
    send_text("922337203685477570");
    wait_drained();
  endtask

  task automatic test_random_numbers();
    logic [63:0] whole;
    int unsigned frac_len;
    int unsigned pos;
    while (live_chars < RANDOM_CHARS) begin
      if ($urandom_range(0, 19) == 0) send_steady = ~send_steady;
      if ($urandom_range(0, 19) == 0) take_steady = ~take_steady;
      if ($urandom_range(0, 1) == 0) push_text("-");
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: whole = 64'($urandom_range(0, 99999));
        5, 6: whole = {$urandom, $urandom} % (64'd10 ** $urandom_range(1, 18));
        default: whole = WHOLE_MAX - 64'd3 + 64'($urandom_range(0, 6));
      endcase
      if ($urandom_range(0, 7) == 0) push_text("0");
      if ($urandom_range(0, 19) != 0) push_text($sformatf("%0d", whole));
      if ($urandom_range(0, 2) != 0) begin
        push_text(".");
        frac_len = $urandom_range(0, 5);
        for (int i = 0; i < frac_len; i++) begin
          if (i >= 2 && $urandom_range(0, 4) != 0) begin
            text_q.push_back(dth_pkg::ChZero);
          end else begin
            text_q.push_back(dth_pkg::ChZero + 8'($urandom_range(0, 9)));
          end
        end
      end
      if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) begin
        pos = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 3))
          0: text_q[pos] = dth_pkg::ChMinus;
          1: text_q[pos] = dth_pkg::ChPoint;
          2: text_q[pos] = 8'h00;
          default: text_q[pos] = 8'($urandom_range(0, 255));
        endcase
      end
      send_number();
      if (numbers_sent % 150 == 0) wait_drained();
    end
    wait_drained();
  endtask

  task automatic test_random_bytes();
    int unsigned len;
    for (int n = 0; n < 40; n++) begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
      send_number();
    end
    wait_drained();
  endtask

  initial begin : result_checker
    int unsigned        stall_cycles;
    dth_pkg::out_item_t want;
    wait (rst_ni === 1'b1);
    forever begin
      stall_cycles = take_steady ? 0 : $urandom_range(0, 5);
      if (stall_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (expected_values.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("Unexpected result beat: ok=%0b value=%0d", out_item_o.ok,
                   out_item_o.value);
        end
      end else begin
        want = expected_values.pop_front();
        values_checked++;
        if (!want.ok) rejects_seen++;
        if (out_item_o.ok !== want.ok || out_item_o.value !== want.value) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Mismatch on result %0d: expected ok=%0b value=%0d, got ok=%0b value=%0d",
                     values_checked, want.ok, want.value, out_item_o.ok, out_item_o.value);
          end
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    send_steady = 1'b0;
    take_steady = 1'b0;
    live_chars = 0;
    numbers_sent = 0;
    values_checked = 0;
    rejects_seen = 0;
    fail_count = 0;
    cycle_count = 0;
    clear_scan();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_forms();
    test_fraction_rules();
    test_malformed();
    test_range_edges();
    test_random_bytes();
    test_random_numbers();

    if (expected_values.size() != 0) begin
      fail_count += expected_values.size();
      $display("%0d expected values never arrived.", expected_values.size());
    end
    $display("Sent %0d numbers (%0d parsed characters); checked %0d values, %0d rejected.",
             numbers_sent, live_chars, values_checked, rejects_seen);
    $display("Covered signs, fractions, range edges, malformed text and raw bytes.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
